// File: src/button_gesture_classifier_macros.svh
// Assertion macros used by the gesture classifier module bgc_classifier.
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define BGC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gesture classifier: same-cycle check failed");

// Next-cycle implication, checked only while reset is released.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gesture classifier: next-cycle check failed");

`endif

// File: src/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Types, constants and helpers shared by the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int TIME_BITS = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CFG_W-1:0]     cfg_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

	localparam cfg_idx_t REG_DEBOUNCE = cfg_idx_t'(0);
	localparam cfg_idx_t REG_WINDOW   = cfg_idx_t'(1);
	localparam cfg_idx_t REG_HOLD     = cfg_idx_t'(2);

	localparam cfg_t DEBOUNCE_RESET = cfg_t'(30);
	localparam cfg_t WINDOW_RESET   = cfg_t'(350);
	localparam cfg_t HOLD_RESET     = cfg_t'(600);

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_CHANGE = 1'b1;

	typedef enum logic [1:0] {
		ACT_SINGLE  = 2'd0,
		ACT_DOUBLE  = 2'd1,
		ACT_HOLD    = 2'd2,
		ACT_RELEASE = 2'd3
	} action_t;

	typedef struct packed {
		cfg_t debounce_ms;
		cfg_t double_window_ms;
		cfg_t hold_ms;
	} cfg_regs_t;

	typedef struct packed {
		logic    valid;
		action_t action;
	} result_t;

	// A timer length wider than the counters saturates at the counter maximum.
	function automatic time_t clamp_time(cfg_t v);
		if (32'(v) > 32'(TIME_MAX)) begin
			return TIME_MAX;
		end
		return time_t'(v);
	endfunction

endpackage

// File: src/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module bgc_cfg_regs
	import bgc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  cfg_idx_t  cfg_index,
	input  cfg_t      cfg_data,
	output cfg_regs_t regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ms      <= DEBOUNCE_RESET;
			regs_q.double_window_ms <= WINDOW_RESET;
			regs_q.hold_ms          <= HOLD_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE: regs_q.debounce_ms      <= cfg_data;
				REG_WINDOW:   regs_q.double_window_ms <= cfg_data;
				REG_HOLD:     regs_q.hold_ms          <= cfg_data;
				default: begin
					// Writes to an unused index are dropped.
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// File: src/bgc_classifier.sv
// ----------------------------------------------------------------------------
// bgc_classifier
// Gesture state, timers and the single-pass classification of one request.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_macros.svh"

module bgc_classifier
	import bgc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  logic      func,
	input  logic      button_level,
	input  cfg_regs_t regs,
	output result_t   result
);

	logic  is_pressed_q, hold_reported_q, click_pending_q;
	logic  hold_running_q, window_running_q;
	time_t since_change_q, hold_left_q, window_left_q;

	logic  is_pressed_d, hold_reported_d, click_pending_d;
	logic  hold_running_d, window_running_d;
	time_t since_change_d, hold_left_d, window_left_d;

	logic  hold_done, window_done, change_ok;
	result_t res;

	assign hold_done   = hold_running_q && (hold_left_q <= time_t'(1));
	assign window_done = window_running_q && (window_left_q <= time_t'(1));
	assign change_ok   = (32'(since_change_q) >= 32'(regs.debounce_ms)) ||
		(since_change_q == TIME_MAX);

	always_comb begin
		is_pressed_d     = is_pressed_q;
		hold_reported_d  = hold_reported_q;
		click_pending_d  = click_pending_q;
		hold_running_d   = hold_running_q;
		window_running_d = window_running_q;
		since_change_d   = since_change_q;
		hold_left_d      = hold_left_q;
		window_left_d    = window_left_q;
		res.valid        = 1'b0;
		res.action       = ACT_SINGLE;

		if (func == FUNC_TICK) begin
			if (since_change_q != TIME_MAX) begin
				since_change_d = since_change_q + time_t'(1);
			end
			if (hold_done) begin
				hold_left_d    = '0;
				hold_running_d = 1'b0;
			end else if (hold_running_q) begin
				hold_left_d = hold_left_q - time_t'(1);
			end
			if (window_done) begin
				window_left_d    = '0;
				window_running_d = 1'b0;
			end else if (window_running_q) begin
				window_left_d = window_left_q - time_t'(1);
			end
			// A hold that expires together with the window wins over the single press.
			priority if (hold_done && is_pressed_q && !hold_reported_q) begin
				hold_reported_d  = 1'b1;
				click_pending_d  = 1'b0;
				window_running_d = 1'b0;
				window_left_d    = '0;
				res.valid        = 1'b1;
				res.action       = ACT_HOLD;
			end else if (window_done && click_pending_q) begin
				click_pending_d = 1'b0;
				res.valid       = 1'b1;
				res.action      = ACT_SINGLE;
			end else begin
			end
		end else if (change_ok) begin
			since_change_d = '0;
			if (button_level != is_pressed_q) begin
				is_pressed_d = button_level;
				if (button_level) begin
					hold_left_d    = clamp_time(regs.hold_ms);
					hold_running_d = 1'b1;
				end else begin
					hold_running_d = 1'b0;
					hold_left_d    = '0;
					priority if (hold_reported_q) begin
						hold_reported_d  = 1'b0;
						click_pending_d  = 1'b0;
						window_running_d = 1'b0;
						window_left_d    = '0;
						res.valid        = 1'b1;
						res.action       = ACT_RELEASE;
					end else if (!click_pending_q) begin
						click_pending_d  = 1'b1;
						window_left_d    = clamp_time(regs.double_window_ms);
						window_running_d = 1'b1;
					end else begin
						click_pending_d  = 1'b0;
						window_running_d = 1'b0;
						window_left_d    = '0;
						res.valid        = 1'b1;
						res.action       = ACT_DOUBLE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q     <= 1'b0;
			hold_reported_q  <= 1'b0;
			click_pending_q  <= 1'b0;
			hold_running_q   <= 1'b0;
			window_running_q <= 1'b0;
			since_change_q   <= TIME_MAX;
			hold_left_q      <= '0;
			window_left_q    <= '0;
		end else if (fire) begin
			is_pressed_q     <= is_pressed_d;
			hold_reported_q  <= hold_reported_d;
			click_pending_q  <= click_pending_d;
			hold_running_q   <= hold_running_d;
			window_running_q <= window_running_d;
			since_change_q   <= since_change_d;
			hold_left_q      <= hold_left_d;
			window_left_q    <= window_left_d;
		end
	end

	assign result = res;

	// A hold can only be outstanding while the button is down.
	`BGC_ASSERT_IMPL(a_hold_needs_press, clk, arst_n, hold_reported_q, is_pressed_q)
	// The double-press window runs exactly while a click is pending.
	`BGC_ASSERT_IMPL(a_window_tracks_click, clk, arst_n, 1'b1,
		click_pending_q == window_running_q)
	// Hold and single press come only from ticks.
	`BGC_ASSERT_IMPL(a_timed_from_tick, clk, arst_n,
		fire && res.valid && (res.action == ACT_HOLD || res.action == ACT_SINGLE),
		func == FUNC_TICK)
	// A tick advances an unsaturated change counter by one.
	`BGC_ASSERT_NEXT(a_since_counts, clk, arst_n,
		fire && func == FUNC_TICK && since_change_q != TIME_MAX,
		since_change_q == $past(since_change_q) + time_t'(1))

endmodule

// File: src/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier: an accepted request is held in the s1 register until it fires into the
// classifier; a gesture it yields is registered in the s2 result register, which drives out_valid.
// Throughput one request per cycle, limited only by stalls on the result side.
// Reset (arst_n low, asynchronous) clears all gesture state and loads default timings.
// ----------------------------------------------------------------------------
module button_gesture_classifier
	import bgc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic                 button_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           action,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_regs_t regs;
	result_t   result;

	logic    valid_s1, func_s1, level_s1;
	logic    out_valid_s2;
	action_t action_s2;
	logic    advance, fire;

	// The result register can take a new value when empty or being drained.
	assign advance  = !out_valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	bgc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_idx_t'(cfg_index)),
		.cfg_data  (cfg_t'(cfg_data)),
		.regs      (regs)
	);

	bgc_classifier u_classifier (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.func         (func_s1),
		.button_level (level_s1),
		.regs         (regs),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			func_s1  <= func;
			level_s1 <= button_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= fire && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire && result.valid) begin
			action_s2 <= result.action;
		end
	end

	assign out_valid = out_valid_s2;
	assign action    = action_s2;

endmodule

// File: bench/tb_button_gesture_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier
// Self-checking bench for the push-button gesture classifier. Ticks and level
// changes are sent through the request channel. A predictor written here
// tracks debounce, the hold timer and the double-press window, and queues the
// gestures it expects. Every result is checked in order against that queue.
// Long timer runs, a long receiver hold-off and random gesture traffic over
// several register settings are covered.
// ----------------------------------------------------------------------------
module tb_button_gesture_classifier;
	import bgc_pkg::*;

	localparam int CYCLE_LIMIT     = 1_500_000;
	localparam int IDLE_CYCLES     = 8;
	localparam int DRAIN_CYCLES    = 16;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_REQUESTS  = 120;
	localparam int MAX_REPORTS     = 20;

	// Index past the end of the register list; writes to it are dropped.
	localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(3);

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     in_valid     = 1'b0;
	logic     in_stall;
	logic     func         = FUNC_TICK;
	logic     button_level = 1'b0;
	logic     out_valid;
	logic     out_stall    = 1'b0;
	logic [1:0] action;
	logic     cfg_wr_en    = 1'b0;
	cfg_idx_t cfg_index    = REG_DEBOUNCE;
	cfg_t     cfg_data     = '0;

	button_gesture_classifier u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state and its copy of the timing registers.
	cfg_t  debounce_len = DEBOUNCE_RESET;
	cfg_t  window_len   = WINDOW_RESET;
	cfg_t  hold_len     = HOLD_RESET;
	logic  pressed      = 1'b0;
	logic  hold_seen    = 1'b0;
	logic  click_open   = 1'b0;
	time_t since_edge   = TIME_MAX;
	time_t hold_count   = '0;
	logic  hold_armed   = 1'b0;
	time_t window_count = '0;
	logic  window_armed = 1'b0;

	action_t pending_actions[$];

	int mismatches       = 0;
	int requests_sent    = 0;
	int settings_used    = 0;
	int gestures_seen[4] = '{0, 0, 0, 0};
	int cycle_count      = 0;
	int burst_left       = 0;
	bit steady           = 1'b0;
	bit hold_off_req     = 1'b0;
	int hold_off_left    = 0;
	int rx_phase_left    = 0;
	rx_mode_t rx_mode    = RX_FREE;

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// Works out the gesture, if any, that one accepted request produces.
	// The registers and counters are both 16 bits wide, so a loaded length
	// never needs to saturate.
	function automatic void classify_item(input logic is_change, input logic level);
		logic hold_done;
		logic window_done;
		hold_done   = 1'b0;
		window_done = 1'b0;
		if (is_change == FUNC_TICK) begin
			if (since_edge != TIME_MAX) begin
				since_edge++;
			end
			if (hold_armed) begin
				if (hold_count <= 1) begin
					hold_count = '0;
					hold_armed = 1'b0;
					hold_done  = 1'b1;
				end else begin
					hold_count--;
				end
			end
			if (window_armed) begin
				if (window_count <= 1) begin
					window_count = '0;
					window_armed = 1'b0;
					window_done  = 1'b1;
				end else begin
					window_count--;
				end
			end
			// A hold beats a window that runs out on the same tick.
			if (hold_done && pressed && !hold_seen) begin
				hold_seen    = 1'b1;
				click_open   = 1'b0;
				window_armed = 1'b0;
				window_count = '0;
				pending_actions.push_back(ACT_HOLD);
			end else if (window_done && click_open) begin
				click_open = 1'b0;
				pending_actions.push_back(ACT_SINGLE);
			end
			return;
		end
		if (since_edge < debounce_len && since_edge != TIME_MAX) begin
			return;
		end
		since_edge = '0;
		if (level == pressed) begin
			return;
		end
		pressed = level;
		if (level) begin
			hold_count = time_t'(hold_len);
			hold_armed = 1'b1;
			return;
		end
		hold_armed = 1'b0;
		hold_count = '0;
		if (hold_seen) begin
			hold_seen    = 1'b0;
			click_open   = 1'b0;
			window_armed = 1'b0;
			window_count = '0;
			pending_actions.push_back(ACT_RELEASE);
		end else if (!click_open) begin
			click_open   = 1'b1;
			window_count = time_t'(window_len);
			window_armed = 1'b1;
		end else begin
			click_open   = 1'b0;
			window_armed = 1'b0;
			window_count = '0;
			pending_actions.push_back(ACT_DOUBLE);
		end
	endfunction

	// Requests are predicted before results are checked, so the queue is
	// up to date even for a result that follows its request closely.
	always @(posedge clk) begin : check_results
		action_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				classify_item(func, button_level);
			end
			if (out_valid && !out_stall) begin
				if (pending_actions.size() == 0) begin
					report_mismatch($sformatf("unexpected action %0d", action));
				end else begin
					want = pending_actions.pop_front();
					if (action !== want) begin
						report_mismatch($sformatf("action %0d, expected %s",
							action, want.name()));
					end
					gestures_seen[want]++;
				end
			end
		end
	end

	// Receiver: a long hold-off on request, otherwise stall patterns picked at
	// random, each kept for a random stretch before the next is picked.
	always @(posedge clk) begin
		if (hold_off_req) begin
			hold_off_req  = 1'b0;
			hold_off_left = HOLD_OFF_CYCLES;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			out_stall <= 1'b1;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode       = rx_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(8, 80);
			end
			rx_phase_left--;
			case (rx_mode)
				RX_FREE: begin
					out_stall <= 1'b0;
				end
				RX_LIGHT: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				RX_HEAVY: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					out_stall <= !out_stall;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge where the request is taken,
	// with valid still high so that the next request can follow at once.
	task automatic send_item(input logic kind, input logic level);
		int gap;
		if (!steady && burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		func         <= kind;
		button_level <= level;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end
		requests_sent++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(FUNC_TICK, 1'($urandom_range(0, 1)));
	endtask

	// A request may leave the block busy without any result, hence the
	// extra cycles once the queue is empty.
	task automatic wait_idle;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_actions.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_DEBOUNCE: debounce_len = value;
			REG_WINDOW:   window_len   = value;
			REG_HOLD:     hold_len     = value;
			default:      ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input cfg_t debounce, input cfg_t window, input cfg_t hold);
		write_reg(REG_DEBOUNCE, debounce);
		write_reg(REG_WINDOW, window);
		write_reg(REG_HOLD, hold);
		settings_used++;
	endtask

	// Default timings straight out of reset: the first change always passes
	// the debounce, the next one does not.
	task automatic test_reset_defaults;
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_CHANGE, 1'b0);
		send_item(FUNC_TICK, 1'b1);
		wait_idle();
	endtask

	task automatic test_directed_gestures;
		set_timing(16'd0, 16'd3, 16'd3);
		// Release of the press left over from the reset test, then a single.
		send_item(FUNC_CHANGE, 1'b0);
		send_ticks(3);
		// Double press.
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_CHANGE, 1'b0);
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_CHANGE, 1'b0);
		// Hold with a repeated level in between, then release after hold.
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_CHANGE, 1'b1);
		send_ticks(3);
		send_item(FUNC_CHANGE, 1'b0);
		// Hold and window run out on the same tick: the hold is seen, not the single.
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_CHANGE, 1'b0);
		send_item(FUNC_CHANGE, 1'b1);
		send_ticks(3);
		send_item(FUNC_CHANGE, 1'b0);
		wait_idle();

		// Zero lengths behave as one tick; the unused index must not land.
		write_reg(REG_UNUSED, 16'hFFFF);
		set_timing(16'd0, 16'd0, 16'd0);
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_TICK, 1'b0);
		send_item(FUNC_CHANGE, 1'b0);
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_CHANGE, 1'b0);
		send_item(FUNC_TICK, 1'b1);
		wait_idle();

		// Debounce of two ticks: changes inside it are dropped.
		set_timing(16'd2, 16'd0, 16'd0);
		send_item(FUNC_CHANGE, 1'b1);
		send_item(FUNC_CHANGE, 1'b0);
		send_ticks(2);
		send_item(FUNC_CHANGE, 1'b0);
		wait_idle();
	endtask

	// Longer timings: the hold timer is taken to one tick short of expiry, and both
	// timers are then run out exactly, with changes spaced past the debounce.
	task automatic test_long_timers;
		set_timing(16'd20, 16'd45, 16'd40);
		steady = 1'b1;
		send_ticks(25);
		// Press released one tick before the hold would be reported.
		send_item(FUNC_CHANGE, 1'b1);
		send_ticks(39);
		send_item(FUNC_CHANGE, 1'b0);
		// The full window runs out into a single press.
		send_ticks(45);
		// A press held for the full hold time, then released.
		send_item(FUNC_CHANGE, 1'b1);
		send_ticks(40);
		send_item(FUNC_CHANGE, 1'b0);
		wait_idle();
		steady = 1'b0;
	endtask

	// The receiver holds off while gestures keep coming, so the block fills
	// and has to stall its request side.
	task automatic test_output_hold_off;
		set_timing(16'd0, 16'd5, 16'd0);
		steady       = 1'b1;
		hold_off_req = 1'b1;
		repeat (30) begin
			send_item(FUNC_CHANGE, 1'b1);
			send_item(FUNC_TICK, 1'($urandom_range(0, 1)));
			send_item(FUNC_CHANGE, 1'b0);
		end
		wait_idle();
		steady = 1'b0;
	endtask

	// Mostly press and release sequences with tick runs of random length,
	// with some repeated levels as noise.
	task automatic test_random_gestures;
		int   taken;
		int   choice;
		int   run_len;
		logic level;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_UNUSED, cfg_t'($urandom()));
			end
			set_timing(cfg_t'($urandom_range(0, 4)), cfg_t'($urandom_range(0, 12)),
				cfg_t'($urandom_range(0, 16)));
			level = pressed;
			taken = 0;
			while (taken < PHASE_REQUESTS) begin
				choice = $urandom_range(0, 9);
				if (choice < 4) begin
					run_len = $urandom_range(1, int'(hold_len) + int'(window_len) + 4);
					send_ticks(run_len);
					taken += run_len;
				end else if (choice < 9) begin
					level = !level;
					send_item(FUNC_CHANGE, level);
					taken++;
				end else begin
					send_item(FUNC_CHANGE, 1'($urandom_range(0, 1)));
					taken++;
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_gestures();
		test_long_timers();
		test_output_hold_off();
		test_random_gestures();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests over %0d timing settings, with a long output hold-off.",
			requests_sent, settings_used);
		$display("Checked %0d single, %0d double, %0d hold and %0d release results.",
			gestures_seen[ACT_SINGLE], gestures_seen[ACT_DOUBLE],
			gestures_seen[ACT_HOLD], gestures_seen[ACT_RELEASE]);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: button_gesture_classifier.f
+incdir+src
src/bgc_pkg.sv
src/bgc_cfg_regs.sv
src/bgc_classifier.sv
src/button_gesture_classifier.sv
bench/tb_button_gesture_classifier.sv
